// ----- hw/rtl/dwfa_pkg.sv -----
// Package for the decreasing worst-fit allocator.
// Holds sizes, action codes and the front-to-back transaction type.
`default_nettype none
package dwfa_pkg;
  localparam int MaxRequests = 32;
  localparam int MaxServers  = 16;
  localparam int AmountBits  = 16;
  localparam int ReqIdxW     = $clog2(MaxRequests);
  localparam int ReqCntW     = $clog2(MaxRequests + 1);
  localparam int SrvIdxW     = $clog2(MaxServers);
  localparam int SrvCntW     = $clog2(MaxServers + 1);
  localparam int QueueDepth  = 2;

  typedef enum logic [1:0] {
    ACT_SERVER  = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_RUN     = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // One classified transaction passed from the front part to the back part.
  typedef struct packed {
    action_t               action;
    logic [AmountBits-1:0] amount;
  } cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/decreasing_worst_fit_allocator.sv -----
// Top level of the decreasing worst-fit allocator.
// Depends on dwfa_pkg, dwfa_front and dwfa_back.
// Load transactions are taken one per cycle through a two-entry queue while it is not full (busy).
// A run sorts n requests with one compare-swap per cycle, then scans
// the m servers for each request and places it.
// Results appear one per strobe; the receiver cannot stall.
// Synchronous active-low reset empties the queue and both stores.
`default_nettype none
module decreasing_worst_fit_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_amount,
  output logic             out_valid,
  output logic [5:0]       out_position,
  output logic [15:0]      out_demand,
  output logic [4:0]       out_server,
  output logic             out_allocated,
  output logic             out_last
);
  import dwfa_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Front part: accept and queue.
  dwfa_front u_front (
    .clk, .rst_n, .start, .in_action, .in_amount, .busy,
    .q_valid, .q_cmd, .q_pop
  );

  // Back part: store, sort and place.
  dwfa_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_position, .out_demand, .out_server,
    .out_allocated, .out_last
  );
endmodule
`default_nettype wire

// ----- hw/rtl/dwfa_front.sv -----
// Front part: accepts input transactions, classifies them and queues them.
// Depends on dwfa_pkg.
`default_nettype none
module dwfa_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_action,
  input  wire logic [15:0]       in_amount,
  output logic                   busy,
  output logic                   q_valid,
  output dwfa_pkg::cmd_t         q_cmd,
  input  wire logic              q_pop
);
  import dwfa_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            queue_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   fill_r;
  logic            push;
  cmd_t            cmd_in;

  // Classify the transaction; the unused code never enters the queue.
  always_comb begin
    cmd_in.action = action_t'(in_action);
    cmd_in.amount = in_amount[AmountBits-1:0];
  end

  assign busy    = (fill_r == (PtrW+1)'(QueueDepth));
  assign push    = start && !busy && (action_t'(in_action) != ACT_NONE);
  assign q_valid = (fill_r != '0);
  assign q_cmd   = queue_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dwfa_back.sv -----
// Back part: holds the stores, sorts requests and places them on servers.
// Depends on dwfa_pkg.
`default_nettype none
module dwfa_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  dwfa_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  output logic [5:0]       out_position,
  output logic [15:0]      out_demand,
  output logic [4:0]       out_server,
  output logic             out_allocated,
  output logic             out_last
);
  import dwfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SORT_RD, ST_SORT_CMP, ST_SCAN, ST_PLACE
  } state_t;

  // Requests live in a small register file sorted by bubble-sort passes.
  logic [AmountBits-1:0] dem_r [MaxRequests];
  logic [AmountBits-1:0] cap_r [MaxServers];
  logic [ReqCntW-1:0]    req_cnt_r;
  logic [SrvCntW-1:0]    srv_cnt_r;
  state_t                state_r;
  logic [ReqCntW-1:0]    pass_r;
  logic [ReqCntW-1:0]    idx_r;
  logic [SrvCntW-1:0]    scan_r;
  logic [SrvIdxW-1:0]    best_r;
  logic                  have_r;
  logic [AmountBits-1:0] best_cap_r;

  logic                  pop_nxt;
  logic [ReqIdxW-1:0]    pos_i;
  logic [AmountBits-1:0] dcur;
  logic                  fits;

  assign q_pop = pop_nxt;
  assign pos_i = idx_r[ReqIdxW-1:0];
  assign dcur  = dem_r[pos_i];
  assign fits  = have_r && (best_cap_r >= dcur);

  always_comb begin
    pop_nxt = 1'b0;
    if (state_r == ST_IDLE && q_valid) pop_nxt = 1'b1;
  end

  // Sequencer: load, bubble sort one compare per cycle, scan, place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      req_cnt_r <= '0;
      srv_cnt_r <= '0;
      out_valid <= 1'b0;
      pass_r    <= '0;
      idx_r     <= '0;
      scan_r    <= '0;
      have_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.action)
              ACT_SERVER: begin
                if (srv_cnt_r < SrvCntW'(MaxServers)) begin
                  cap_r[srv_cnt_r[SrvIdxW-1:0]] <= q_cmd.amount;
                  srv_cnt_r <= srv_cnt_r + 1'b1;
                end
              end
              ACT_REQUEST: begin
                if (req_cnt_r < ReqCntW'(MaxRequests)) begin
                  dem_r[req_cnt_r[ReqIdxW-1:0]] <= q_cmd.amount;
                  req_cnt_r <= req_cnt_r + 1'b1;
                end
              end
              ACT_RUN: begin
                if (req_cnt_r == '0) begin
                  srv_cnt_r <= '0;
                end else begin
                  pass_r  <= '0;
                  idx_r   <= '0;
                  state_r <= ST_SORT_CMP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SORT_CMP: begin
          // One adjacent compare-swap per cycle over n passes.
          if (idx_r + 1'b1 < req_cnt_r) begin
            if (dem_r[pos_i] < dem_r[pos_i + 1'b1]) begin
              dem_r[pos_i]        <= dem_r[pos_i + 1'b1];
              dem_r[pos_i + 1'b1] <= dem_r[pos_i];
            end
            idx_r <= idx_r + 1'b1;
          end else if (pass_r + 1'b1 < req_cnt_r) begin
            pass_r <= pass_r + 1'b1;
            idx_r  <= '0;
          end else begin
            idx_r   <= '0;
            scan_r  <= '0;
            have_r  <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Find the first server holding the most remaining capacity.
          if (scan_r < srv_cnt_r) begin
            if (!have_r || cap_r[scan_r[SrvIdxW-1:0]] > best_cap_r) begin
              best_r     <= scan_r[SrvIdxW-1:0];
              best_cap_r <= cap_r[scan_r[SrvIdxW-1:0]];
              have_r     <= 1'b1;
            end
            scan_r <= scan_r + 1'b1;
          end else begin
            state_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          out_valid     <= 1'b1;
          out_position  <= 6'(idx_r + 1'b1);
          out_demand    <= dcur;
          out_allocated <= fits;
          out_server    <= fits ? 5'(best_r) + 5'd1 : '0;
          out_last      <= (idx_r + 1'b1 == req_cnt_r);
          if (fits) cap_r[best_r] <= best_cap_r - dcur;
          if (idx_r + 1'b1 == req_cnt_r) begin
            req_cnt_r <= '0;
            srv_cnt_r <= '0;
            state_r   <= ST_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            scan_r  <= '0;
            have_r  <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dwfa_checker.sv -----
// Port checker for the decreasing worst-fit allocator, bound to the top.
// Depends on decreasing_worst_fit_allocator through its bind.
`default_nettype none
module dwfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic [5:0]  out_position,
  input wire logic [4:0]  out_server,
  input wire logic        out_allocated,
  input wire logic        out_last
);
  // A failed placement never names a server.
  a_unalloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_allocated |-> out_server == 5'd0)
    else $error("unallocated result names a server");

  // A placed request names a real server.
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_allocated |-> out_server != 5'd0)
    else $error("allocated result without server");

  // A position is never zero.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position != 6'd0)
    else $error("zero position");

  // The last result of a run is followed by a cycle without a result.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after last");
endmodule

bind decreasing_worst_fit_allocator dwfa_checker u_dwfa_checker (
  .clk, .rst_n, .out_valid, .out_position, .out_server,
  .out_allocated, .out_last
);
`default_nettype wire
